>>> rtl/fixed_slot_free_list_allocator_defines.svh
// Assertion macros shared by the free-list allocator RTL.
// Standalone header: no dependencies. Define ASSERT_OFF to compile the checks out.
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF

// Plain property, checked on every edge outside reset
`define FSA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define FSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define FSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define FSA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

>>> rtl/fsa_pkg.sv
// Shared types and codes for the fixed-slot free-list allocator.
// No dependencies; imported by fsa_ctrl, fsa_dp and the top level.
`timescale 1ns / 1ps

package fsa_pkg;

	// Field widths fixed by the interface
	localparam int ADDR_W    = 32;
	localparam int CNT_W     = 11;
	localparam int CFG_IDX_W = 8;

	// Item kinds
	localparam logic [1:0] KIND_ALLOC  = 2'd0;
	localparam logic [1:0] KIND_FREE   = 2'd1;
	localparam logic [1:0] KIND_PROBE  = 2'd2;
	localparam logic [1:0] KIND_REINIT = 2'd3;

	// Result status codes
	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_EMPTY    = 2'd1;
	localparam logic [1:0] STAT_OUTSIDE  = 2'd2;
	localparam logic [1:0] STAT_ALL_FREE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_POOL_BASE  = 8'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLOT_COUNT = 8'd1;

	// Slot count after reset
	localparam logic [CNT_W-1:0] SLOT_COUNT_RST = 11'd1024;

	typedef struct packed {
		logic [1:0]        kind;
		logic [ADDR_W-1:0] address;
	} req_t;

	typedef struct packed {
		logic [1:0]        status;
		logic [ADDR_W-1:0] slot_address;
		logic              in_pool;
		logic [CNT_W-1:0]  free_slots;
		logic [CNT_W-1:0]  total_slots;
		logic [ADDR_W-1:0] allocations_done;
		logic [ADDR_W-1:0] frees_done;
	} rsp_t;

	// Controller -> datapath commands
	typedef struct packed {
		logic cap;      // load the request register
		logic exec;     // carry out the held item, load the response register
		logic link_ld;  // take the link read data as the new head
	} fsa_cmd_t;

	// Datapath -> controller status
	typedef struct packed {
		logic link_rd;  // held item is an allocate that pops a linked slot
	} fsa_sts_t;

endpackage

>>> rtl/fsa_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module fsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> rtl/fsa_ctrl.sv
// Sequencing state machine of the free-list allocator.
// Depends on fsa_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "fixed_slot_free_list_allocator_defines.svh"

module fsa_ctrl
	import fsa_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  fsa_sts_t sts,
	output fsa_cmd_t cmd
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_EXEC = 2'd1;
	localparam logic [1:0] ST_LINK = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       out_valid_q;
	logic       out_free;

	// response register can take a new beat
	assign out_free = !out_valid_q || !rsp_stall;

	assign req_stall   = (state_q != ST_IDLE);
	assign rsp_valid   = out_valid_q;
	assign cmd.cap     = (state_q == ST_IDLE) && req_valid;
	assign cmd.exec    = (state_q == ST_EXEC) && out_free;
	assign cmd.link_ld = (state_q == ST_LINK);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (out_free) begin
					state_d = sts.link_rd ? ST_LINK : ST_IDLE;
				end
			end
			ST_LINK: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`FSA_ASSERT_NXT(a_link_follows_pop, clk, arst_n, cmd.exec && sts.link_rd, cmd.link_ld, "link load missing after linked pop")
	`FSA_ASSERT_NXT(a_exec_gives_beat, clk, arst_n, cmd.exec, rsp_valid, "executed item left no response beat")
	`FSA_ASSERT_IMP(a_no_overwrite, clk, arst_n, cmd.exec && rsp_valid, !rsp_stall, "response overwritten while stalled")

endmodule

>>> rtl/fsa_dp.sv
// Datapath of the free-list allocator: config registers, pool state, link RAM,
// request and response registers. Depends on fsa_pkg, fsa_ram and the macro header.
`timescale 1ns / 1ps
`include "fixed_slot_free_list_allocator_defines.svh"

module fsa_dp
	import fsa_pkg::*;
#(
	parameter int SLOT_BYTES = 64,
	parameter int MAX_SLOTS  = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  req_t                 req,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data,
	input  fsa_cmd_t             cmd,
	output fsa_sts_t             sts
);

	localparam int SHIFT     = $clog2(SLOT_BYTES);      // slot size is a power of two
	localparam int AW        = $clog2(MAX_SLOTS);
	localparam int CW        = $clog2(MAX_SLOTS + 1);
	localparam int RST_TOTAL = (1024 > MAX_SLOTS) ? MAX_SLOTS : 1024;
	localparam logic [ADDR_W:0] RST_END = (ADDR_W + 1)'(RST_TOTAL) << SHIFT;

	// config registers
	logic [ADDR_W-1:0] cfg_base_q;
	logic [CNT_W-1:0]  cfg_slots_q;

	// latched pool geometry
	logic [ADDR_W-1:0] base_q, base_d;
	logic [CW-1:0]     total_q, total_d;
	logic [ADDR_W:0]   end_q, end_d;

	// free-list state
	logic [CW-1:0]     head_q, head_d;
	logic [CW-1:0]     untch_q, untch_d;
	logic [CW-1:0]     fc_q, fc_d;
	logic [ADDR_W-1:0] at_q, at_d;
	logic [ADDR_W-1:0] ft_q, ft_d;

	// request register
	logic [1:0]        kind_q;
	logic [ADDR_W-1:0] addr_q;

	// item results
	logic [1:0]        status_d;
	logic [ADDR_W-1:0] saddr_d;
	logic              inpool_d;
	logic              in_range;
	logic [ADDR_W-1:0] offset;
	logic [CW-1:0]     free_slot;
	logic [CW-1:0]     clamp;
	logic              ram_we;
	logic              ram_re;
	logic [CW-1:0]     ram_rdata;
	rsp_t              rsp_q;

	assign cfg_ready = 1'b1;
	assign rsp       = rsp_q;

	// pool membership and slot index of the held address
	assign in_range  = ({1'b0, addr_q} >= {1'b0, base_q}) && ({1'b0, addr_q} < end_q);
	assign offset    = addr_q - base_q;
	assign free_slot = CW'(offset >> SHIFT);

	// slot count clamped to 1..MAX_SLOTS
	always_comb begin
		if (cfg_slots_q == '0) begin
			clamp = CW'(1);
		end else if (32'(cfg_slots_q) > 32'(MAX_SLOTS)) begin
			clamp = CW'(MAX_SLOTS);
		end else begin
			clamp = CW'(cfg_slots_q);
		end
	end

	assign sts.link_rd = (kind_q == KIND_ALLOC) && (fc_q != '0) && (head_q < untch_q);

	// item execution
	always_comb begin
		base_d   = base_q;
		total_d  = total_q;
		end_d    = end_q;
		head_d   = head_q;
		untch_d  = untch_q;
		fc_d     = fc_q;
		at_d     = at_q;
		ft_d     = ft_q;
		status_d = STAT_OK;
		saddr_d  = '0;
		inpool_d = 1'b0;
		ram_we   = 1'b0;
		ram_re   = 1'b0;
		case (kind_q)
			KIND_ALLOC: begin
				if (fc_q == '0) begin
					status_d = STAT_EMPTY;
				end else begin
					if (head_q >= untch_q) begin
						untch_d = head_q + 1'b1;
						head_d  = head_q + 1'b1;
					end else begin
						ram_re = 1'b1;
					end
					fc_d    = fc_q - 1'b1;
					at_d    = at_q + 1'b1;
					saddr_d = base_q + (ADDR_W'(head_q) << SHIFT);
				end
			end
			KIND_FREE: begin
				inpool_d = in_range;
				if (!in_range) begin
					status_d = STAT_OUTSIDE;
				end else if (fc_q >= total_q) begin
					status_d = STAT_ALL_FREE;
				end else begin
					ram_we = 1'b1;
					head_d = free_slot;
					fc_d   = fc_q + 1'b1;
					ft_d   = ft_q + 1'b1;
				end
			end
			KIND_PROBE: begin
				inpool_d = in_range;
			end
			KIND_REINIT: begin
				base_d  = cfg_base_q;
				total_d = clamp;
				end_d   = {1'b0, cfg_base_q} + ((ADDR_W + 1)'(clamp) << SHIFT);
				head_d  = '0;
				untch_d = '0;
				fc_d    = clamp;
				at_d    = '0;
				ft_d    = '0;
			end
			default: begin
				status_d = STAT_OK;
			end
		endcase
	end

	// link memory: one entry per slot
	fsa_ram #(
		.WIDTH(CW),
		.DEPTH(MAX_SLOTS)
	) u_link_ram (
		.clk  (clk),
		.we   (cmd.exec && ram_we),
		.waddr(free_slot[AW-1:0]),
		.wdata(head_q),
		.re   (cmd.exec && ram_re),
		.raddr(head_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// control and pool state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_base_q  <= '0;
			cfg_slots_q <= SLOT_COUNT_RST;
			base_q      <= '0;
			total_q     <= CW'(RST_TOTAL);
			end_q       <= RST_END;
			head_q      <= '0;
			untch_q     <= '0;
			fc_q        <= CW'(RST_TOTAL);
			at_q        <= '0;
			ft_q        <= '0;
		end else begin
			if (cfg_valid && cfg_index == REG_POOL_BASE) begin
				cfg_base_q <= cfg_data;
			end
			if (cfg_valid && cfg_index == REG_SLOT_COUNT) begin
				cfg_slots_q <= cfg_data[CNT_W-1:0];
			end
			if (cmd.exec) begin
				base_q  <= base_d;
				total_q <= total_d;
				end_q   <= end_d;
				head_q  <= head_d;
				untch_q <= untch_d;
				fc_q    <= fc_d;
				at_q    <= at_d;
				ft_q    <= ft_d;
			end else if (cmd.link_ld) begin
				head_q <= ram_rdata;
			end
		end
	end

	// request and response payload
	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			kind_q <= req.kind;
			addr_q <= req.address;
		end
		if (cmd.exec) begin
			rsp_q.status           <= status_d;
			rsp_q.slot_address     <= saddr_d;
			rsp_q.in_pool          <= inpool_d;
			rsp_q.free_slots       <= CNT_W'(fc_d);
			rsp_q.total_slots      <= CNT_W'(total_d);
			rsp_q.allocations_done <= at_d;
			rsp_q.frees_done       <= ft_d;
		end
	end

	`FSA_ASSERT(a_count_bound, clk, arst_n, fc_q <= total_q, "free count above pool size")
	`FSA_ASSERT_IMP(a_geometry_hold, clk, arst_n, !$past(cmd.exec), $stable(base_q) && $stable(total_q), "pool geometry changed without an item")
	`FSA_ASSERT_IMP(a_link_exclusive, clk, arst_n, cmd.link_ld, !cmd.exec && !cmd.cap, "link load overlaps another command")

endmodule

>>> rtl/fixed_slot_free_list_allocator.sv
// Top level of the fixed-slot free-list allocator.
// Depends on fsa_pkg, fsa_ctrl, fsa_dp (and through it fsa_ram).
`timescale 1ns / 1ps

// Hands out and takes back equal slots of SLOT_BYTES bytes (a power of two) from a
// pool at pool_base. Each request beat (allocate, free, probe, reinitialize) returns
// one response beat. One request is in flight at a time: a request is captured, then
// executed into the response register; an allocate that pops a previously freed slot
// then loads the next head from the link RAM, whose read data is registered. A new
// request is taken while the previous response still waits on rsp_stall. pool_base
// and slot_count are sampled only at reset and at a reinitialize request; write them
// while the block is idle. cfg_ready is always high. Freed slots come back LIFO,
// above the never-used slots in ascending order.
module fixed_slot_free_list_allocator
	import fsa_pkg::*;
#(
	parameter int SLOT_BYTES = 64,
	parameter int MAX_SLOTS  = 1024
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  req_t                 req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output rsp_t                 rsp,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	fsa_cmd_t cmd;
	fsa_sts_t sts;

	// sequencing
	fsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// pool state and results
	fsa_dp #(
		.SLOT_BYTES(SLOT_BYTES),
		.MAX_SLOTS (MAX_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule

>>> tb/sv/fixed_slot_free_list_allocator_test.sv
// Self-checking testbench for the fixed-slot free-list allocator: directed beats, then
// random traffic over several pool settings, every response checked field by field.
// Depends on fsa_pkg and the fixed_slot_free_list_allocator RTL.
`timescale 1ns / 1ps

module fixed_slot_free_list_allocator_test;
	import fsa_pkg::*;

	localparam int SLOT_BYTES = 64;
	localparam int MAX_SLOTS  = 1024;
	localparam int PHASE_BEATS = 205;
	// index that maps to no register; writes to it must be dropped
	localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 8'd2;

	logic                 clk;
	logic                 arst_n;
	logic                 req_valid;
	logic                 req_stall;
	req_t                 req;
	logic                 rsp_valid;
	logic                 rsp_stall;
	rsp_t                 rsp;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [ADDR_W-1:0]    cfg_data;

	// Shadow of the pool: registers, latched setting, link store and counters.
	// Every accepted request beat yields the response it must produce.
	class alloc_scoreboard;
		logic [31:0] base_reg;
		logic [10:0] count_reg;
		logic [31:0] base_lat;
		int unsigned total_lat;
		int unsigned link_mem [MAX_SLOTS];
		bit          link_set [MAX_SLOTS];
		int unsigned head;
		int unsigned untouched;
		int unsigned free_left;
		logic [31:0] allocs;
		logic [31:0] frees;
		int unsigned live_slots [$];   // slots currently handed out
		rsp_t        replies_due [$];
		int          kind_seen [4];
		int          status_seen [4];
		int          errors;
		int          checked;

		function new();
			base_reg = '0;
			count_reg = SLOT_COUNT_RST;
			errors = 0;
			checked = 0;
			foreach (link_set[i]) link_set[i] = 1'b0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
			init_pool();
		endfunction

		// latch registers, clamp the slot count, everything free again
		function void init_pool();
			if (count_reg == 0)
				total_lat = 1;
			else if (count_reg > MAX_SLOTS)
				total_lat = MAX_SLOTS;
			else
				total_lat = count_reg;
			base_lat = base_reg;
			head = 0;
			untouched = 0;
			free_left = total_lat;
			allocs = '0;
			frees = '0;
			live_slots.delete();
		endfunction

		function void note_config(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
			if (idx == REG_POOL_BASE)
				base_reg = val;
			else if (idx == REG_SLOT_COUNT)
				count_reg = val[10:0];
		endfunction

		// an allocate now would follow a link that was never stored
		function bit link_unset();
			return free_left != 0 && head < untouched && head < MAX_SLOTS && !link_set[head];
		endfunction

		function rsp_t step_pool(input req_t r);
			rsp_t o;
			longint unsigned lo, hi, a;
			int unsigned s;
			o = '0;
			lo = base_lat;
			hi = lo + longint'(total_lat) * SLOT_BYTES;
			a = r.address;
			case (r.kind)
				KIND_ALLOC: begin
					if (free_left == 0) begin
						o.status = STAT_EMPTY;
					end else begin
						s = head;
						// untouched run ascends; below it the freed slots are linked
						if (s >= untouched) begin
							untouched = s + 1;
							head = s + 1;
						end else begin
							head = (s < MAX_SLOTS) ? link_mem[s] : 0;
						end
						free_left--;
						allocs++;
						o.slot_address = base_lat + 32'(s) * 32'(SLOT_BYTES);
						live_slots = {live_slots, s};
					end
				end
				KIND_FREE, KIND_PROBE: begin
					o.in_pool = (a >= lo && a < hi);
					if (r.kind == KIND_FREE) begin
						if (!o.in_pool) begin
							o.status = STAT_OUTSIDE;
						end else if (free_left >= total_lat) begin
							o.status = STAT_ALL_FREE;
						end else begin
							s = int'((a - lo) / SLOT_BYTES);
							if (s < MAX_SLOTS) begin
								link_mem[s] = head;
								link_set[s] = 1'b1;
							end
							head = s;
							free_left++;
							frees++;
							for (int i = 0; i < live_slots.size(); i++) begin
								if (live_slots[i] == s) begin
									live_slots.delete(i);
									break;
								end
							end
						end
					end
				end
				default: init_pool();
			endcase
			o.free_slots = 11'(free_left);
			o.total_slots = 11'(total_lat);
			o.allocations_done = allocs;
			o.frees_done = frees;
			return o;
		endfunction

		function void note_request(input req_t r);
			rsp_t o;
			o = step_pool(r);
			kind_seen[r.kind]++;
			status_seen[o.status]++;
			replies_due = {replies_due, o};
		endfunction

		task report(input string what);
			errors++;
			if (errors <= 20)
				$display("mismatch: %s", what);
		endtask

		task check_response(input rsp_t got);
			rsp_t want;
			logic [63:0] g [7];
			logic [63:0] w [7];
			string tag [7];
			tag = '{"status", "slot_address", "in_pool", "free_slots", "total_slots",
				"allocations_done", "frees_done"};
			if (replies_due.size() == 0) begin
				report("response beat with no request outstanding");
				return;
			end
			want = replies_due.pop_front();
			checked++;
			g = '{got.status, got.slot_address, got.in_pool, got.free_slots,
				got.total_slots, got.allocations_done, got.frees_done};
			w = '{want.status, want.slot_address, want.in_pool, want.free_slots,
				want.total_slots, want.allocations_done, want.frees_done};
			for (int i = 0; i < 7; i++) begin
				if (g[i] !== w[i])
					report($sformatf("response %0d %s: got %0h, want %0h",
						checked, tag[i], g[i], w[i]));
			end
		endtask
	endclass

	alloc_scoreboard sb = new();
	bit alloc_lean = 1'b1;
	int settings = 1;

	fixed_slot_free_list_allocator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic req_t pool_req(input logic [1:0] kind, input logic [31:0] address);
		req_t r;
		r.kind = kind;
		r.address = address;
		return r;
	endfunction

	// addresses around the pool edges, inside it, or anywhere
	function automatic logic [31:0] address_near_pool();
		logic [31:0] lo, top;
		lo = sb.base_lat;
		top = lo + 32'(sb.total_lat * SLOT_BYTES);
		case ($urandom_range(0, 4))
			0: return lo + 32'($urandom_range(0, sb.total_lat * SLOT_BYTES - 1));
			1: return lo - 32'($urandom_range(1, SLOT_BYTES));
			2: return top - 32'd1 + 32'($urandom_range(0, SLOT_BYTES));
			3: return lo + 32'($urandom_range(0, SLOT_BYTES - 1));
			default: return $urandom();
		endcase
	endfunction

	// Random traffic: allocate and free in tides so the pool fills and drains;
	// most frees hand back live slots, the rest are stray or repeated.
	function automatic req_t next_pool_req();
		req_t r;
		int roll;
		int unsigned s;
		roll = $urandom_range(0, 99);
		r.address = $urandom();
		if (sb.free_left == 0 && $urandom_range(0, 3) == 0)
			alloc_lean = 1'b0;
		if (sb.live_slots.size() == 0 && $urandom_range(0, 3) == 0)
			alloc_lean = 1'b1;
		if ($urandom_range(0, 39) == 0)
			alloc_lean = !alloc_lean;
		if (roll == 0) begin
			r.kind = KIND_REINIT;
		end else if (roll < 11) begin
			r.kind = KIND_PROBE;
			r.address = address_near_pool();
		end else if (roll < (alloc_lean ? 70 : 35)) begin
			r.kind = KIND_ALLOC;
		end else begin
			r.kind = KIND_FREE;
			if (sb.live_slots.size() != 0 && $urandom_range(0, 3) != 0) begin
				s = sb.live_slots[$urandom_range(0, sb.live_slots.size() - 1)];
				r.address = sb.base_lat + 32'(s) * 32'(SLOT_BYTES)
					+ 32'($urandom_range(0, SLOT_BYTES - 1));
			end else begin
				r.address = address_near_pool();
			end
		end
		if (r.kind == KIND_ALLOC && sb.link_unset())
			r.kind = KIND_PROBE;
		return r;
	endfunction

	// one request beat; returns at the accepting edge with valid still high
	task automatic offer(input req_t item);
		req <= item;
		req_valid <= 1'b1;
		@(posedge clk);
		while (req_stall !== 1'b0) @(posedge clk);
		sb.note_request(item);
	endtask

	// stop sending and wait until every response is back and the block is quiet
	task automatic settle();
		req_valid <= 1'b0;
		while (sb.replies_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic program_pool(input logic [31:0] base_word, input logic [31:0] count_word);
		logic [CFG_IDX_W-1:0] idx [3];
		logic [31:0] val [3];
		idx = '{REG_POOL_BASE, REG_SLOT_COUNT, REG_UNMAPPED};
		val = '{base_word, count_word, $urandom()};
		for (int i = 0; i < 3; i++) begin
			cfg_valid <= 1'b1;
			cfg_index <= idx[i];
			cfg_data <= val[i];
			@(posedge clk);
			while (cfg_ready !== 1'b1) @(posedge clk);
			sb.note_config(idx[i], val[i]);
		end
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// reinitialize, then bursts of random beats with random gaps
	task automatic run_pool_phase(input int n);
		int burst;
		offer(pool_req(KIND_REINIT, $urandom()));
		while (n > 0) begin
			burst = $urandom_range(1, 30);
			while (burst > 0 && n > 0) begin
				offer(next_pool_req());
				burst--;
				n--;
			end
			if ($urandom_range(0, 2) != 0) begin
				req_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
		end
	endtask

	// Response side: stall modes change now and then; twice a long hold backs the block up
	initial begin : rsp_side
		int beats;
		int mode;
		int mode_left;
		int hold_left;
		beats = 0;
		mode = 0;
		mode_left = 0;
		hold_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_stall == 1'b0) begin
				sb.check_response(rsp);
				beats++;
				if (beats == 500 || beats == 1300)
					hold_left = 200;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 80);
			end
			mode_left--;
			if (hold_left != 0) begin
				hold_left--;
				rsp_stall <= 1'b1;
			end else begin
				case (mode)
					0: rsp_stall <= 1'b0;
					1: rsp_stall <= ($urandom_range(0, 3) == 0);
					2: rsp_stall <= ($urandom_range(0, 3) != 0);
					default: rsp_stall <= !rsp_stall;
				endcase
			end
		end
	end

	initial begin : stimulus
		logic [31:0] base;
		int cnt;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset pool: base 0, 1024 slots
		offer(pool_req(KIND_PROBE, 32'h0000_0000));
		offer(pool_req(KIND_PROBE, 32'h0000_FFFF));   // last byte of the last slot
		offer(pool_req(KIND_PROBE, 32'h0001_0000));   // first byte past the end
		offer(pool_req(KIND_FREE, 32'h0000_0040));    // nothing handed out yet
		offer(pool_req(KIND_FREE, 32'hFFFF_FFFF));    // outside
		offer(pool_req(KIND_ALLOC, 32'hFFFF_FFFF));   // address is don't-care
		offer(pool_req(KIND_ALLOC, 32'h0000_0000));
		offer(pool_req(KIND_ALLOC, 32'h0000_0000));
		offer(pool_req(KIND_FREE, 32'h0000_007F));    // slot 1, offset bits dropped
		offer(pool_req(KIND_FREE, 32'h0000_0000));
		offer(pool_req(KIND_ALLOC, 32'h0000_0000));   // last freed comes back first
		offer(pool_req(KIND_ALLOC, 32'h0000_0000));   // next one through the link
		offer(pool_req(KIND_FREE, 32'h0000_1000));    // never handed out, pushed anyway
		offer(pool_req(KIND_ALLOC, 32'h0000_0000));
		settle();

		// one slot at the very top; count 0 clamps to 1
		program_pool(32'hFFFF_FFC0, 32'hFFFF_F800);
		offer(pool_req(KIND_PROBE, 32'h0000_0040));   // new setting not live yet
		offer(pool_req(KIND_REINIT, 32'hFFFF_FFFF));
		offer(pool_req(KIND_PROBE, 32'hFFFF_FFBF));
		offer(pool_req(KIND_ALLOC, 32'h0000_0000));
		offer(pool_req(KIND_ALLOC, 32'h0000_0000));   // pool empty
		offer(pool_req(KIND_FREE, 32'hFFFF_FFFF));
		offer(pool_req(KIND_FREE, 32'hFFFF_FFC0));    // every slot already free
		settle();

		// count above the maximum clamps
		program_pool(32'h8000_0000, 32'h0000_07FF);
		offer(pool_req(KIND_REINIT, 32'h0000_0000));
		offer(pool_req(KIND_PROBE, 32'h8000_FFFF));
		offer(pool_req(KIND_ALLOC, 32'h0000_0000));
		settle();

		// random phases, mostly small pools so they fill and drain
		for (int p = 0; p < 9; p++) begin
			case (p)
				0: cnt = 8;
				1: cnt = 1;
				2: cnt = 2;
				3: cnt = 0;
				4: cnt = 2047;
				5: cnt = $urandom_range(3, 40);
				6: cnt = 16;
				7: cnt = $urandom_range(1, 64);
				default: cnt = MAX_SLOTS;
			endcase
			case (p)
				1: base = 32'h0000_0000;
				3: base = 32'hFFFF_FFC0;
				6: base = 32'hFFFF_FE00;    // slots past 8 wrap the address space
				default: base = $urandom() & ~32'(SLOT_BYTES - 1);
			endcase
			program_pool(base, ($urandom() & 32'hFFFF_F800) | 32'(cnt));
			run_pool_phase(PHASE_BEATS);
			settle();
		end

		$display("covered %0d allocate, %0d free, %0d probe, %0d reinit beats over %0d pool settings",
			sb.kind_seen[KIND_ALLOC], sb.kind_seen[KIND_FREE], sb.kind_seen[KIND_PROBE],
			sb.kind_seen[KIND_REINIT], settings);
		$display("outcomes: %0d ok, %0d pool empty, %0d outside, %0d already free; %0d checked",
			sb.status_seen[STAT_OK], sb.status_seen[STAT_EMPTY], sb.status_seen[STAT_OUTSIDE],
			sb.status_seen[STAT_ALL_FREE], sb.checked);
		if (sb.errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// hang guard
	initial begin : watchdog
		#1_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
